// ===== design/pket_pkg.sv =====
// Package for the per-key extremes tracker: table size, field widths,
// status codes, the item and ZIP-group structs and the cell control and status structs. No dependencies.
package pket_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int KEY_W   = 16;
  localparam int ZIP_W   = 17;
  localparam int LAT_W   = 28;
  localparam int LON_W   = 29;
  localparam int INDEX_W = 6;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_UPDATED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEW     = 2'd1;
  localparam logic [STAT_W-1:0] ST_SKIPPED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic                    clear_first;
    logic [KEY_W-1:0]        group_key;
    logic [ZIP_W-1:0]        zip_code;
    logic signed [LAT_W-1:0] latitude_udeg;
    logic signed [LON_W-1:0] longitude_udeg;
  } item_t;

  typedef struct packed {
    logic [ZIP_W-1:0] low_lon_zip;
    logic [ZIP_W-1:0] high_lon_zip;
    logic [ZIP_W-1:0] high_lat_zip;
    logic [ZIP_W-1:0] low_lat_zip;
  } zips_t;

  typedef struct packed {
    logic upd_en;
    logic found_any;
  } cell_ctl_t;

  typedef struct packed {
    logic live;
    logic hit;
    logic alloc;
  } cell_stat_t;

endpackage

// ===== design/pket_cell.sv =====
// One table entry of the extremes tracker: key, four extremes and their ZIPs.
// Takes the fill state from its left neighbor and passes its own to the right.
// Depends on pket_pkg.
module pket_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pket_pkg::item_t    query,
  input  pket_pkg::cell_ctl_t ctl,
  input  logic               prev_live,
  output pket_pkg::cell_stat_t stat,
  output pket_pkg::zips_t    zips_nxt
);
  import pket_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [KEY_W-1:0]        key_r;
  logic signed [LON_W-1:0] low_lon_r, high_lon_r;
  logic signed [LAT_W-1:0] high_lat_r, low_lat_r;
  zips_t                   zips_r;
  logic signed [LON_W-1:0] low_lon_nxt, high_lon_nxt;
  logic signed [LAT_W-1:0] high_lat_nxt, low_lat_nxt;
  logic                    live, key_nz, hit, alloc;

  assign key_nz = (query.group_key != '0);
  assign live   = valid_r && !query.clear_first;
  assign hit    = live && key_nz && (key_r == query.group_key);
  assign alloc  = !live && prev_live && key_nz && !ctl.found_any;

  assign stat.live  = live;
  assign stat.hit   = hit;
  assign stat.alloc = alloc;

  always_comb begin
    low_lon_nxt  = low_lon_r;
    high_lon_nxt = high_lon_r;
    high_lat_nxt = high_lat_r;
    low_lat_nxt  = low_lat_r;
    zips_nxt     = zips_r;
    if (alloc) begin
      low_lon_nxt           = query.longitude_udeg;
      high_lon_nxt          = query.longitude_udeg;
      high_lat_nxt          = query.latitude_udeg;
      low_lat_nxt           = query.latitude_udeg;
      zips_nxt.low_lon_zip  = query.zip_code;
      zips_nxt.high_lon_zip = query.zip_code;
      zips_nxt.high_lat_zip = query.zip_code;
      zips_nxt.low_lat_zip  = query.zip_code;
    end else if (hit) begin
      if ($signed(query.longitude_udeg) < $signed(low_lon_r)) begin
        low_lon_nxt          = query.longitude_udeg;
        zips_nxt.low_lon_zip = query.zip_code;
      end
      if ($signed(query.longitude_udeg) > $signed(high_lon_r)) begin
        high_lon_nxt          = query.longitude_udeg;
        zips_nxt.high_lon_zip = query.zip_code;
      end
      if ($signed(query.latitude_udeg) > $signed(high_lat_r)) begin
        high_lat_nxt          = query.latitude_udeg;
        zips_nxt.high_lat_zip = query.zip_code;
      end
      if ($signed(query.latitude_udeg) < $signed(low_lat_r)) begin
        low_lat_nxt          = query.latitude_udeg;
        zips_nxt.low_lat_zip = query.zip_code;
      end
    end
  end

  assign valid_nxt = ctl.upd_en ? (live || alloc) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      if (alloc) begin
        key_r <= query.group_key;
      end
      low_lon_r  <= low_lon_nxt;
      high_lon_r <= high_lon_nxt;
      high_lat_r <= high_lat_nxt;
      low_lat_r  <= low_lat_nxt;
      zips_r     <= zips_nxt;
    end
  end

endmodule

// ===== design/per_key_extremes_tracker.sv =====
// Top level of the per-key extremes tracker: input register, row of table
// cells, hit selection and output register. Depends on pket_pkg, pket_cell.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   clear_first, key, zip, lat, lon
//   out_      output     out_valid / out_ready status, entry_index, four ZIPs
//
// An item is first registered; then every cell compares its key and updates
// itself, with the result loaded into the output register.
// The compare-and-update step runs only while the output register is empty or
// being drained, so a stalled output holds the item in the input register.
// Reset invalidates all entries at once; no clearing pass is needed.
module per_key_extremes_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_clear_first,
  input  logic [pket_pkg::KEY_W-1:0]        in_group_key,
  input  logic [pket_pkg::ZIP_W-1:0]        in_zip_code,
  input  logic signed [pket_pkg::LAT_W-1:0] in_latitude_udeg,
  input  logic signed [pket_pkg::LON_W-1:0] in_longitude_udeg,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pket_pkg::STAT_W-1:0]       out_status,
  output logic [pket_pkg::INDEX_W-1:0]      out_entry_index,
  output logic [pket_pkg::ZIP_W-1:0]        out_low_lon_zip,
  output logic [pket_pkg::ZIP_W-1:0]        out_high_lon_zip,
  output logic [pket_pkg::ZIP_W-1:0]        out_high_lat_zip,
  output logic [pket_pkg::ZIP_W-1:0]        out_low_lat_zip
);
  import pket_pkg::*;

  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  item_t       item_r;
  logic        proc;
  cell_ctl_t   ctl;
  cell_stat_t  stat [TABLE_ENTRIES];
  zips_t       cell_zips [TABLE_ENTRIES];
  logic [TABLE_ENTRIES:0] live_chain;
  logic        found_any, alloc_any;
  zips_t       sel_zips;
  logic [SLOT_W-1:0] sel_slot;
  logic [SLOT_W+INDEX_W-1:0] slot_ext;
  logic [STAT_W-1:0] status_nxt;
  logic [STAT_W-1:0] status_r;
  logic [INDEX_W-1:0] index_r;
  zips_t       zips_r;

  assign in_ready = !busy_r;
  assign proc     = busy_r && (!out_valid_r || out_ready);

  always_comb begin
    found_any = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      found_any = found_any | stat[i].hit;
    end
  end

  assign ctl.upd_en    = proc;
  assign ctl.found_any = found_any;
  assign live_chain[0] = 1'b1;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pket_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .query     (item_r),
      .ctl       (ctl),
      .prev_live (live_chain[g]),
      .stat      (stat[g]),
      .zips_nxt  (cell_zips[g])
    );
    assign live_chain[g+1] = stat[g].live;
  end

  always_comb begin
    alloc_any = 1'b0;
    sel_zips  = '0;
    sel_slot  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      alloc_any = alloc_any | stat[i].alloc;
      if (stat[i].hit || stat[i].alloc) begin
        sel_zips = sel_zips | cell_zips[i];
        sel_slot = sel_slot | SLOT_W'(i);
      end
    end
  end

  assign slot_ext = {{INDEX_W{1'b0}}, sel_slot};

  always_comb begin
    priority if (item_r.group_key == '0) begin
      status_nxt = ST_SKIPPED;
    end else if (found_any) begin
      status_nxt = ST_UPDATED;
    end else if (alloc_any) begin
      status_nxt = ST_NEW;
    end else begin
      status_nxt = ST_FULL;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (proc) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.clear_first    <= in_clear_first;
      item_r.group_key      <= in_group_key;
      item_r.zip_code       <= in_zip_code;
      item_r.latitude_udeg  <= in_latitude_udeg;
      item_r.longitude_udeg <= in_longitude_udeg;
    end
    if (proc) begin
      status_r <= status_nxt;
      index_r  <= slot_ext[INDEX_W-1:0];
      zips_r   <= sel_zips;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_entry_index  = index_r;
  assign out_low_lon_zip  = zips_r.low_lon_zip;
  assign out_high_lon_zip = zips_r.high_lon_zip;
  assign out_high_lat_zip = zips_r.high_lat_zip;
  assign out_low_lat_zip  = zips_r.low_lat_zip;

endmodule

// ===== design/pket_checker.sv =====
// Port-level checks for the per-key extremes tracker, bound to the top level.
// Depends on pket_pkg and per_key_extremes_tracker.
module pket_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pket_pkg::STAT_W-1:0]       out_status,
  input logic [pket_pkg::INDEX_W-1:0]      out_entry_index,
  input logic [pket_pkg::ZIP_W-1:0]        out_low_lon_zip,
  input logic [pket_pkg::ZIP_W-1:0]        out_high_lon_zip,
  input logic [pket_pkg::ZIP_W-1:0]        out_high_lat_zip,
  input logic [pket_pkg::ZIP_W-1:0]        out_low_lat_zip
);
  import pket_pkg::*;

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SKIPPED || out_status == ST_FULL) |->
      out_entry_index == '0 && out_low_lon_zip == '0 && out_high_lon_zip == '0 &&
      out_high_lat_zip == '0 && out_low_lat_zip == '0)
    else $error("skipped or dropped item reports nonzero fields");

  a_new_seed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEW |->
      out_low_lon_zip == out_high_lon_zip && out_low_lon_zip == out_high_lat_zip &&
      out_low_lon_zip == out_low_lat_zip)
    else $error("new entry not seeded with one ZIP");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_index) && $stable(out_low_lon_zip))
    else $error("stalled result changed");

endmodule

bind per_key_extremes_tracker pket_checker u_pket_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_entry_index  (out_entry_index),
  .out_low_lon_zip  (out_low_lon_zip),
  .out_high_lon_zip (out_high_lon_zip),
  .out_high_lat_zip (out_high_lat_zip),
  .out_low_lat_zip  (out_low_lat_zip)
);
